// File: rtl/qpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared widths, register map and types of the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

	localparam int KEY_W   = 31;
	localparam int SIZE_W  = 15;
	localparam int SLOT_W  = 14;
	localparam int COUNT_W = 15;
	localparam int TOTAL_W = 40;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 15'd2;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 15'd2;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// operands of the shared add / compare-subtract unit
	typedef struct packed {
		logic [SIZE_W:0] a;
		logic [SIZE_W:0] b;
	} mod_op_t;

endpackage

// File: rtl/qpht_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_if
// Request and response channels of the quadratic probe hash table.
// ----------------------------------------------------------------------------
interface qpht_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [qpht_pkg::KEY_W-1:0] key_value;

	modport source (output valid, output req_type, output key_value, input ready);
	modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface qpht_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        success;
	logic [qpht_pkg::SLOT_W-1:0]  slot_index;
	logic [qpht_pkg::COUNT_W-1:0] probe_count;
	logic [qpht_pkg::TOTAL_W-1:0] probe_total;

	modport source (output valid, output success, output slot_index, output probe_count,
		output probe_total, input ready);
	modport sink   (input valid, input success, input slot_index, input probe_count,
		input probe_total, output ready);
endinterface

// File: rtl/qpht_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_mod_unit
// Shared add and conditional subtract of the table size: (a + b) mod size
// for any a + b below twice the size. Serves divider steps and probe steps.
// ----------------------------------------------------------------------------
module qpht_mod_unit (
	input  qpht_pkg::mod_op_t             op,
	input  logic [qpht_pkg::SIZE_W-1:0]   size,
	output logic [qpht_pkg::SIZE_W-1:0]   res
);
	import qpht_pkg::*;

	logic [SIZE_W+1:0] sum;
	logic [SIZE_W+1:0] diff;

	assign sum  = {1'b0, op.a} + {1'b0, op.b};
	assign diff = sum - {2'b00, size};
	assign res  = (sum >= {2'b00, size}) ? diff[SIZE_W-1:0] : sum[SIZE_W-1:0];

endmodule

// File: rtl/qpht_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_slot_store
// Key memory, one write and one registered read port, with a clearing
// sweep after reset that zeroes one slot per cycle.
// ----------------------------------------------------------------------------
module qpht_slot_store #(
	parameter int MAX_SLOTS = 16384,
	parameter int AW        = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [qpht_pkg::KEY_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [qpht_pkg::KEY_W-1:0]  wr_data,
	output logic                        clr_busy
);
	import qpht_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

	logic [KEY_W-1:0] mem [MAX_SLOTS];
	logic [AW-1:0]    clr_addr_q;
	logic             clr_busy_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign we    = clr_busy_q | wr_en;
	assign waddr = clr_busy_q ? clr_addr_q : wr_addr;
	assign wdata = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// File: rtl/quadratic_probe_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing key table with quadratic probing from key mod size.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   req     | in  | valid / ready      | req_type, key_value
//   rsp     | out | valid / ready      | success, slot_index, probe_count,
//           |     |                    | probe_total
//   apb     | in  | psel, penable, ... | table_size at byte 0
//
// An item passes an accept step, the bit-serial key mod size through the
// shared mod unit, a memory read and then a compare for each probe, and a
// finish step. After reset a clearing sweep zeroes the key memory, during
// which req.ready stays low; configuration writes are taken as ever.
// The result sits in an output register; the next item is accepted while it
// waits, and its finish cycle stalls until the previous result is taken.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core #(
	parameter int MAX_SLOTS = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qpht_pkg::ADDR_W-1:0]   paddr,
	input  logic [qpht_pkg::DATA_W-1:0]   pwdata,
	output logic [qpht_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	qpht_req_if.sink                      req,
	qpht_rsp_if.source                    rsp
);
	import qpht_pkg::*;

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [SIZE_W+1:0] MAX_EXT  = (SIZE_W + 2)'(MAX_SLOTS);
	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_SLOTS);
	localparam logic [4:0]        DIV_TOP  = 5'(KEY_W - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	// configuration
	logic [SIZE_W-1:0] table_size_q;
	logic [SIZE_W-1:0] size;
	logic              cfg_wr;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1] == REG_TABLE_SIZE);
	assign cfg_wr  = psel & penable & pwrite & pready & reg_sel;
	assign prdata  = reg_sel ? {{(DATA_W - SIZE_W){1'b0}}, table_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			table_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (table_size_q < SIZE_MIN) begin
			size = SIZE_MIN;
		end else if ({2'b00, table_size_q} > MAX_EXT) begin
			size = MAX_SIZE;
		end else begin
			size = table_size_q;
		end
	end

	// sequencer
	logic [2:0]        state_q;
	logic              type_q;
	logic [KEY_W-1:0]  key_q;
	logic [4:0]        bit_q;
	logic [SIZE_W-1:0] slot_q;   // remainder during the divide, then probe slot
	logic [SIZE_W-1:0] nslot_q;
	logic [SIZE_W-1:0] delta_q;  // (2i + 1) mod size
	logic [SIZE_W-1:0] idx_q;
	logic              exh_q;
	logic              match_q;
	logic [TOTAL_W-1:0] total_q;

	logic              rsp_valid_q;
	logic              success_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic [COUNT_W-1:0] count_q;
	logic [TOTAL_W-1:0] total_out_q;

	mod_op_t           op;
	logic [SIZE_W-1:0] mod_res;
	logic [KEY_W-1:0]  rd_data;
	logic              clr_busy;
	logic              mem_wr;
	logic              out_free;
	logic [COUNT_W-1:0] count;
	logic [TOTAL_W:0]  total_sum;
	logic [TOTAL_W-1:0] total_next;
	logic              success;

	always_comb begin
		case (state_q)
			S_DIV:   begin
				op.a = {slot_q, key_q[bit_q]};
				op.b = '0;
			end
			S_RD:    begin
				op.a = {1'b0, slot_q};
				op.b = {1'b0, delta_q};
			end
			S_CMP:   begin
				op.a = {1'b0, delta_q};
				op.b = (SIZE_W + 1)'(2);
			end
			default: begin
				op.a = '0;
				op.b = '0;
			end
		endcase
	end

	qpht_mod_unit u_mod (
		.op   (op),
		.size (size),
		.res  (mod_res)
	);

	assign out_free   = ~rsp_valid_q | rsp.ready;
	assign count      = COUNT_W'(idx_q + 1'b1);
	assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(count);
	assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
	assign success    = ~exh_q & (key_q != '0) & ((type_q == REQ_INSERT) | match_q);
	assign mem_wr     = (state_q == S_FIN) & out_free & (type_q == REQ_INSERT) &
		~exh_q & (key_q != '0);

	qpht_slot_store #(
		.MAX_SLOTS (MAX_SLOTS),
		.AW        (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (state_q == S_RD),
		.rd_addr  (AW'(slot_q)),
		.rd_data  (rd_data),
		.wr_en    (mem_wr),
		.wr_addr  (AW'(slot_q)),
		.wr_data  (key_q),
		.clr_busy (clr_busy)
	);

	assign req.ready = (state_q == S_IDLE) & ~clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (idx_q == size || rd_data == '0 || rd_data == key_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (type_q == REQ_LOOKUP) begin
							total_q <= total_next;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				type_q <= req.req_type;
				key_q  <= req.key_value;
				bit_q  <= DIV_TOP;
				slot_q <= '0;
			end
			S_DIV: begin
				slot_q  <= mod_res;
				bit_q   <= bit_q - 1'b1;
				delta_q <= SIZE_W'(1);
				idx_q   <= '0;
			end
			S_RD: begin
				nslot_q <= mod_res;
			end
			S_CMP: begin
				exh_q   <= (idx_q == size);
				match_q <= (rd_data == key_q);
				if (idx_q != size && rd_data != '0 && rd_data != key_q) begin
					idx_q   <= idx_q + 1'b1;
					slot_q  <= nslot_q;
					delta_q <= mod_res;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			success_q   <= success;
			count_q     <= count;
			total_out_q <= (type_q == REQ_LOOKUP) ? total_next : total_q;
			// an insert that runs out of probes reports slot zero
			if (type_q == REQ_INSERT && exh_q) begin
				slot_out_q <= '0;
			end else begin
				slot_out_q <= slot_q[SLOT_W-1:0];
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.success     = success_q;
	assign rsp.slot_index  = slot_out_q;
	assign rsp.probe_count = count_q;
	assign rsp.probe_total = total_out_q;

endmodule

// File: rtl/qpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks of the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
module qpht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [qpht_pkg::ADDR_W-1:0]   paddr,
	input logic [qpht_pkg::DATA_W-1:0]   pwdata,
	input logic [qpht_pkg::DATA_W-1:0]   prdata,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [qpht_pkg::TOTAL_W-1:0]  rsp_probe_total
);
	import qpht_pkg::*;

	logic [TOTAL_W-1:0] seen_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_total_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			seen_total_q <= rsp_probe_total;
		end
	end

	// one item at a time: accepting drops ready
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req.ready high in cycle after accept");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp.valid dropped while stalled");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_probe_total >= seen_total_q)
		else $error("probe_total went down");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[ADDR_W-1] == REG_TABLE_SIZE
		|=> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
		else $error("table_size readback mismatch");

endmodule

bind quadratic_probe_hash_table_core qpht_checker u_qpht_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr),
	.pwdata          (pwdata),
	.prdata          (prdata),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_probe_total (rsp.probe_total)
);

// File: tb/quadratic_probe_hash_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core_tb
// Drives inserts and lookups into the probe table and checks every response
// against a local table model, over a range of table sizes and backpressure.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core_tb;

	import qpht_pkg::*;

	localparam int          SLOTS      = 16384;
	localparam int          IDLE_LIMIT = 200000;
	localparam logic [ADDR_W-1:0] TABLE_SIZE_ADDR = ADDR_W'(REG_TABLE_SIZE) << 2;
	localparam longint unsigned   TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
	localparam logic [KEY_W-1:0]  KEY_MAX   = '1;

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
	} probe_request_t;

	typedef struct packed {
		logic               success;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
	} probe_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	qpht_req_if req_ch();
	qpht_rsp_if rsp_ch();

	quadratic_probe_hash_table_core #(
		.MAX_SLOTS(SLOTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// local copy of the table
	logic [KEY_W-1:0]   slot_keys [SLOTS];
	logic [TOTAL_W-1:0] probe_sum;
	logic [SIZE_W-1:0]  size_setting;

	probe_request_t   pending_requests[$];
	probe_result_t    expected_results[$];
	logic [KEY_W-1:0] recent_keys[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned idle_cycles;

	always #10 clk = ~clk;

	function automatic longint unsigned active_span();
		if (size_setting < SIZE_MIN)
			return SIZE_MIN;
		if (size_setting > SLOTS)
			return SLOTS;
		return size_setting;
	endfunction

	task automatic predict_probe(input logic op, input logic [KEY_W-1:0] key);
		longint unsigned span, home, slot, idx;
		probe_result_t   res;
		span = active_span();
		home = longint'(key) % span;
		slot = home;
		idx  = 0;
		while (idx < span && slot_keys[slot] != '0 && slot_keys[slot] != key) begin
			idx++;
			slot = (home + idx * idx) % span;
		end
		res.success = 1'b0;
		res.count   = COUNT_W'(idx + 1);
		if (op == REQ_LOOKUP) begin
			res.success = (idx < span && key != '0 && slot_keys[slot] == key);
			res.slot    = SLOT_W'(slot);
			if (longint'(probe_sum) > TOTAL_MAX - (idx + 1))
				probe_sum = TOTAL_W'(TOTAL_MAX);
			else
				probe_sum = probe_sum + TOTAL_W'(idx + 1);
		end else if (idx < span) begin
			res.slot = SLOT_W'(slot);
			if (key != '0) begin
				slot_keys[slot] = key;
				res.success     = 1'b1;
			end
		end else begin
			res.slot = '0;
		end
		res.total = probe_sum;
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (mismatch_count < 100)
			$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == TABLE_SIZE_ADDR)
			size_setting = data[SIZE_W-1:0];
	endtask

	task automatic push_request(input logic op, input logic [KEY_W-1:0] key);
		probe_request_t r;
		r.op  = op;
		r.key = key;
		pending_requests.push_back(r);
		if (op == REQ_INSERT) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 48)
				void'(recent_keys.pop_front());
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mix of reused keys, home collisions, small values and full-width values
	function automatic logic [KEY_W-1:0] pick_key(input longint unsigned span);
		int unsigned     pick;
		longint unsigned mult;
		pick = $urandom_range(99);
		if (pick < 35 && recent_keys.size() != 0)
			return recent_keys[$urandom_range(recent_keys.size() - 1)];
		if (pick < 55) begin
			mult = $urandom_range(0, 32'h7FFF_FFFF / span - 1);
			return KEY_W'(span * mult + $urandom_range(0, 2));
		end
		if (pick < 60)
			return KEY_W'($urandom_range(0, 15));
		if (pick < 63) begin
			case ($urandom_range(2))
				0: return '0;
				1: return KEY_W'(1);
				default: return KEY_MAX;
			endcase
		end
		return KEY_W'($urandom);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.req_type  <= REQ_INSERT;
			req_ch.key_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_probe(req_ch.req_type, req_ch.key_value);
				void'(pending_requests.pop_front());
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid     <= 1'b1;
					req_ch.req_type  <= pending_requests[0].op;
					req_ch.key_value <= pending_requests[0].key;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		probe_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item, probe_count", rsp_ch.probe_count, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.success !== want.success)
						report_mismatch("success", rsp_ch.success, want.success);
					if (rsp_ch.slot_index !== want.slot)
						report_mismatch("slot_index", rsp_ch.slot_index, want.slot);
					if (rsp_ch.probe_count !== want.count)
						report_mismatch("probe_count", rsp_ch.probe_count, want.count);
					if (rsp_ch.probe_total !== want.total)
						report_mismatch("probe_total", rsp_ch.probe_total, want.total);
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: covers the clearing sweep and the longest probe run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL quadratic_probe_hash_table_core");
				$finish;
			end
		end
	end

	initial begin
		int unsigned     phase_size  [10] = '{0, 3, 7, 13, 31, 101, 1021, 16384, 32767, 16381};
		int unsigned     phase_items [10] = '{40, 80, 110, 120, 150, 200, 180, 120, 60, 60};
		longint unsigned span;
		logic            op;

		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_INSERT;
		req_ch.key_value = '0;
		rsp_ch.ready     = 1'b0;
		send_idle_pct    = 24;
		recv_stall_pct   = 69;
		mismatch_count   = 0;
		idle_cycles      = 0;
		probe_sum        = '0;
		size_setting     = SIZE_RESET;
		for (int s = 0; s < SLOTS; s++)
			slot_keys[s] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// two-slot table straight out of reset
		@(negedge clk);
		push_request(REQ_LOOKUP, KEY_W'(5));
		push_request(REQ_INSERT, '0);           // zero key never stored
		push_request(REQ_LOOKUP, '0);
		push_request(REQ_INSERT, KEY_MAX);
		push_request(REQ_INSERT, KEY_W'(4));
		push_request(REQ_INSERT, KEY_W'(4));    // rewrite in place
		push_request(REQ_INSERT, KEY_W'(6));    // table full: probes run out
		push_request(REQ_LOOKUP, KEY_W'(6));
		push_request(REQ_LOOKUP, KEY_W'(3));
		push_request(REQ_LOOKUP, KEY_MAX);
		push_request(REQ_LOOKUP, '0);
		push_request(REQ_INSERT, '0);
		wait_drained();

		// grow to three slots: old keys stay where they were
		write_reg(TABLE_SIZE_ADDR, DATA_W'(3));
		@(negedge clk);
		push_request(REQ_LOOKUP, KEY_W'(4));
		push_request(REQ_INSERT, KEY_W'(4));
		push_request(REQ_LOOKUP, KEY_MAX);
		push_request(REQ_LOOKUP, KEY_W'(1));
		push_request(REQ_INSERT, KEY_W'(1));
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			write_reg(TABLE_SIZE_ADDR, DATA_W'(phase_size[p]));
			span = active_span();
			if (p < 4) begin
				send_idle_pct  = 24;
				recv_stall_pct = 69;
			end else if (p < 7) begin
				send_idle_pct  = 69;
				recv_stall_pct = 24;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			@(negedge clk);
			for (int n = 0; n < phase_items[p]; n++) begin
				// sender holds off once until the pipeline is empty
				if (p == 4 && n == phase_items[p] / 2) begin
					wait_drained();
					@(negedge clk);
				end
				op = ($urandom_range(1) == 0) ? REQ_INSERT : REQ_LOOKUP;
				push_request(op, pick_key(span));
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS quadratic_probe_hash_table_core");
		else
			$display("FAIL quadratic_probe_hash_table_core");
		$finish;
	end

endmodule

// File: files.f
rtl/qpht_pkg.sv
rtl/qpht_if.sv
rtl/qpht_mod_unit.sv
rtl/qpht_slot_store.sv
rtl/quadratic_probe_hash_table_core.sv
rtl/qpht_checker.sv
tb/quadratic_probe_hash_table_core_tb.sv
